>>> rtl/core/slg_pkg.sv
// Shared constants and types for the shuffled LCG random generator.
`timescale 1ns / 1ps
`default_nettype none

package slg_pkg;

    localparam int VAL_W       = 31;
    localparam int MUL_W       = 15;
    localparam int PROD_W      = VAL_W + MUL_W;
    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 2);

    localparam logic [VAL_W-1:0] SEED_MASK = 31'h3fc9_1ab4;
    localparam logic [VAL_W-1:0] LCG_MOD   = 31'h7fff_ffff;
    localparam logic [MUL_W-1:0] LCG_MUL   = 15'd16807;

    // step index of the last reseed step (slot select, table fill, core value)
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TABLE_SLOTS + 1);

    typedef struct packed {
        logic             go;
        logic [VAL_W-1:0] operand;
    } step_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] result;
    } step_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/slg_ifs.sv
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps
`default_nettype none

interface slg_req_if;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [slg_pkg::VAL_W-1:0] seed;

    modport source (output valid, output cmd, output seed, input ready);
    modport sink   (input valid, input cmd, input seed, output ready);
endinterface

interface slg_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [slg_pkg::VAL_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

>>> rtl/core/slg_ram.sv
// Generic single-clock RAM, one write and one read port, registered read.
`timescale 1ns / 1ps
`default_nettype none

module slg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/slg_step.sv
// Two-stage Park-Miller step: x * 16807 mod (2^31 - 1).
`timescale 1ns / 1ps
`default_nettype none

module slg_step (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire slg_pkg::step_req_t req,
    output slg_pkg::step_rsp_t      rsp
);

    logic [slg_pkg::PROD_W-1:0] prod_reg;
    logic [slg_pkg::PROD_W-1:0] prod_next;
    logic                       busy_reg;
    logic                       done_reg;
    logic [slg_pkg::VAL_W-1:0]  result_reg;
    logic [slg_pkg::VAL_W-1:0]  result_next;
    logic [slg_pkg::VAL_W:0]    fold_sum;

    assign prod_next = {{slg_pkg::MUL_W{1'b0}}, req.operand}
                     * {{slg_pkg::VAL_W{1'b0}}, slg_pkg::LCG_MUL};

    // 2^31 == 1 mod the modulus: add high part into low part, one correction
    assign fold_sum = {1'b0, prod_reg[slg_pkg::VAL_W-1:0]}
                    + {{(slg_pkg::VAL_W + 1 - slg_pkg::MUL_W){1'b0}},
                       prod_reg[slg_pkg::PROD_W-1:slg_pkg::VAL_W]};

    always_comb
    begin
        if (fold_sum >= {1'b0, slg_pkg::LCG_MOD})
        begin
            result_next = slg_pkg::VAL_W'(fold_sum - {1'b0, slg_pkg::LCG_MOD});
        end
        else
        begin
            result_next = fold_sum[slg_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= req.go;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

`default_nettype wire

>>> rtl/core/shuffled_lcg_random_generator_core.sv
// Top level: shuffled Park-Miller generator with table RAM and sequencer.
`timescale 1ns / 1ps
`default_nettype none

// A draw beat (cmd = 1) returns the selected shuffle-table entry on rsp: one
// table RAM read that overlaps the step unit (multiply, then Mersenne fold),
// then the write-back. A reseed beat (cmd = 0) gives no response and runs 18
// chained steps through the same step unit. One beat is in work at a time; a
// finished number waits in the output register and stalls only the next
// draw's completion. Draws before the first reseed return 0.

module shuffled_lcg_random_generator_core (
    input  wire logic clk,
    input  wire logic rst_n,
    slg_req_if.sink   req,
    slg_rsp_if.source rsp
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SEED = 4'b0010,
        ST_DRAW = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [slg_pkg::CNT_W-1:0]   cnt_reg;
    logic [slg_pkg::CNT_W-1:0]   cnt_next;
    logic [slg_pkg::CNT_W-1:0]   cnt_m1;
    logic [slg_pkg::VAL_W-1:0]   lcg_reg;
    logic [slg_pkg::VAL_W-1:0]   lcg_next;
    logic [slg_pkg::SLOT_W-1:0]  slot_reg;
    logic [slg_pkg::SLOT_W-1:0]  slot_next;
    logic                        live_reg;
    logic                        live_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    logic [slg_pkg::VAL_W-1:0]   number_reg;
    logic [slg_pkg::VAL_W-1:0]   number_next;

    slg_pkg::step_req_t          step_req;
    slg_pkg::step_rsp_t          step_rsp;

    logic                        accept;
    logic                        out_free;
    logic [slg_pkg::VAL_W-1:0]   seed_mix;
    logic [slg_pkg::VAL_W-1:0]   rd_data;
    logic [slg_pkg::VAL_W-1:0]   drawn;
    logic                        wr_en;
    logic [slg_pkg::SLOT_W-1:0]  wr_addr;
    logic                        rd_en;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign seed_mix = (req.seed == slg_pkg::SEED_MASK) ? req.seed
                                                       : (req.seed ^ slg_pkg::SEED_MASK);

    // table reads as zero until the first reseed has filled it
    assign drawn  = live_reg ? rd_data : '0;
    assign cnt_m1 = cnt_reg - 1'b1;

    assign rd_en = accept && req.cmd;

    always_comb
    begin
        step_req.go      = 1'b0;
        step_req.operand = step_rsp.result;
        wr_en            = 1'b0;
        wr_addr          = slot_reg;
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        lcg_next         = lcg_reg;
        slot_next        = slot_reg;
        live_next        = live_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        number_next      = number_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_req.go      = 1'b1;
                    step_req.operand = req.cmd ? lcg_reg : seed_mix;
                    cnt_next         = '0;
                    state_next       = req.cmd ? ST_DRAW : ST_SEED;
                end
            end
            ST_SEED:
            begin
                if (step_rsp.done)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == '0)
                    begin
                        slot_next = step_rsp.result[slg_pkg::SLOT_W-1:0];
                    end
                    if (cnt_reg == slg_pkg::LAST_STEP)
                    begin
                        lcg_next   = step_rsp.result;
                        live_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_req.go = 1'b1;
                        if (cnt_reg != '0)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = cnt_m1[slg_pkg::SLOT_W-1:0];
                        end
                    end
                end
            end
            ST_DRAW:
            begin
                if (step_rsp.done)
                begin
                    wr_en     = 1'b1;
                    lcg_next  = step_rsp.result;
                    slot_next = drawn[slg_pkg::SLOT_W-1:0];
                    if (out_free)
                    begin
                        rsp_valid_next = 1'b1;
                        number_next    = drawn;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    number_next    = drawn;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            lcg_reg       <= '0;
            slot_reg      <= '0;
            live_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            lcg_reg       <= lcg_next;
            slot_reg      <= slot_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        number_reg <= number_next;
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.number = number_reg;

    slg_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (step_req),
        .rsp   (step_rsp)
    );

    slg_ram #(
        .WIDTH (slg_pkg::VAL_W),
        .DEPTH (slg_pkg::TABLE_SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (step_rsp.result),
        .rd_en   (rd_en),
        .rd_addr (slot_reg),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/slg_chk.sv
// Port-level checker for the shuffled LCG generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module slg_chk (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      req_valid,
    input wire logic                      req_ready,
    input wire logic                      req_cmd,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire logic [slg_pkg::VAL_W-1:0] rsp_number
);

    logic req_beat;

    assign req_beat = req_valid && req_ready;

    // draw into an empty output register shows its number after the step busy and done registers and the valid register
    a_draw_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat && req_cmd && !rsp_valid |-> ##3 rsp_valid)
        else $error("draw beat produced no response in time");

    // reseed never creates a response beat
    a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat && !req_cmd && !rsp_valid |=> !rsp_valid)
        else $error("reseed produced a response beat");

    // one beat in work at a time
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> !req_ready)
        else $error("request taken while previous beat in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_number))
        else $error("stalled response changed");

endmodule

bind shuffled_lcg_random_generator_core slg_chk u_slg_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_cmd    (req.cmd),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_number (rsp.number)
);

`default_nettype wire
